@@ rtl/stp_pkg.sv @@
// shared constants, types and functions of the sepia tone pixel unit
package stp_pkg;

	localparam int unsigned ChanW = 8;
	localparam int unsigned SumW  = 10;
	localparam int unsigned AvgW  = 9;
	localparam int unsigned ProdW = 18;
	localparam int unsigned QW    = 24;
	localparam int unsigned DivW  = 32;
	localparam int unsigned RomDepth = 256;

	// floor(s / 3) as (s * 683) >> 11, exact for s up to 765
	localparam logic [9:0]  Recip3   = 10'd683;
	// ceil(2^41 / 255): floor(p * 16384 / 255) = (p * Recip1) >> 27 for 18-bit p
	localparam logic [33:0] Recip1   = 34'd8623620611;
	// ceil(2^40 / 255): floor(y / 255) = (y * Recip255) >> 40 for 32-bit y
	localparam logic [32:0] Recip255 = 33'd4311810306;

	typedef logic [ChanW-1:0] gamma_rom_t [RomDepth];

	// entry i is the largest v with v^8 <= i^5 * 255^3
	function automatic gamma_rom_t build_gamma();
		gamma_rom_t rom;
		logic [63:0] v;
		logic [63:0] nxt;
		logic [63:0] p;
		logic [63:0] tgt;
		logic [63:0] i64;
		v = 64'd0;
		for (int i = 0; i < RomDepth; i++) begin
			i64 = 64'(i);
			tgt = i64 * i64 * i64 * i64 * i64 * 64'd16581375;
			for (int k = 0; k < RomDepth; k++) begin
				if (v < 64'd255) begin
					nxt = v + 64'd1;
					p = nxt * nxt;
					p = p * p;
					p = p * p;
					if (p <= tgt) begin
						v = nxt;
					end
				end
			end
			rom[i] = v[ChanW-1:0];
		end
		return rom;
	endfunction

	// scale by 1.75 and clip to a byte
	function automatic logic [ChanW-1:0] to_byte(input logic [QW-1:0] q);
		logic [QW+2:0] prod;
		logic [8:0] x;
		prod = {3'b000, q} * 27'd7;
		x = prod[QW+2:18];
		return x[8] ? 8'hff : x[ChanW-1:0];
	endfunction

endpackage

@@ rtl/sepia_tone_pixel_unit.sv @@
// top level of the sepia tone pixel unit: mix pipeline, byte scaling and gamma lookup
//
// recolors one 8-bit rgb pixel per transfer into a sepia tone with a 1/1.6 gamma
// input channel: in_valid / in_ready with red_in, green_in, blue_in
// output channel: out_valid / out_ready with red_out, green_out, blue_out
// every input transfer yields exactly one output transfer, in order
// an input transfer reaches out_valid through seven mix stages, one scale-and-clip
// stage and one gamma lookup stage that is the output register
// throughput: one pixel per clock while out_ready is high
// the whole pipeline advances together; the multiplier stages by reciprocal
// constants set the stage depth
// when the receiver stalls with a result waiting, every stage holds and in_ready
// drops in the same cycle; nothing is lost or repeated
// arst_n clears all valid bits; the gamma table is a constant and needs no load
module sepia_tone_pixel_unit
	import stp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ChanW-1:0] red_in,
	input  logic [ChanW-1:0] green_in,
	input  logic [ChanW-1:0] blue_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ChanW-1:0] red_out,
	output logic [ChanW-1:0] green_out,
	output logic [ChanW-1:0] blue_out
);

	localparam gamma_rom_t GammaRom = build_gamma();

	logic          en;
	logic          mix_vld;
	logic [QW-1:0] mix_r, mix_g, mix_b;

	logic             v_s8, v_s9;
	logic [ChanW-1:0] r_s8, g_s8, b_s8;
	logic [ChanW-1:0] r_s9, g_s9, b_s9;

	assign en       = !v_s9 || out_ready;
	assign in_ready = en;

	stp_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (in_valid),
		.red     (red_in),
		.green   (green_in),
		.blue    (blue_in),
		.mix_vld (mix_vld),
		.mix_r   (mix_r),
		.mix_g   (mix_g),
		.mix_b   (mix_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s8 <= mix_vld;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s8 <= to_byte(mix_r);
			g_s8 <= to_byte(mix_g);
			b_s8 <= to_byte(mix_b);
			r_s9 <= GammaRom[r_s8];
			g_s9 <= GammaRom[g_s8];
			b_s9 <= GammaRom[b_s8];
		end
	end

	assign out_valid = v_s9;
	assign red_out   = r_s9;
	assign green_out = g_s9;
	assign blue_out  = b_s9;

endmodule

@@ rtl/stp_mix.sv @@
// seven-stage gray averaging and cross-mix datapath, q8.16 results
module stp_mix
	import stp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld,
	input  logic [ChanW-1:0] red,
	input  logic [ChanW-1:0] green,
	input  logic [ChanW-1:0] blue,
	output logic             mix_vld,
	output logic [QW-1:0]    mix_r,
	output logic [QW-1:0]    mix_g,
	output logic [QW-1:0]    mix_b
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [AvgW-1:0]  g2_s1, b2_s1;
	logic [ProdW-1:0] p_s2;
	logic [AvgW-1:0]  b2_s2, b2_s3;
	logic [QW-1:0]    mr_s3, mr_s4, mr_s5, mr_s6, mr_s7;
	logic [DivW-1:0]  y_s4;
	logic [QW-1:0]    mg_s5, mg_s6, mg_s7;
	logic [DivW-1:0]  z_s6;
	logic [QW-1:0]    mb_s7;

	logic [SumW-1:0]  sum;
	logic [19:0]      gray_prod;
	logic [ChanW-1:0] gray;
	logic [51:0]      mr_prod;
	logic [32:0]      q_prod;
	logic [64:0]      mg_prod;
	logic [47:0]      z_prod;
	logic [64:0]      mb_prod;

	assign sum       = SumW'(red) + SumW'(green) + SumW'(blue);
	assign gray_prod = 20'(sum) * 20'(Recip3);
	assign gray      = gray_prod[18:11];
	assign mr_prod   = 52'(p_s2) * 52'(Recip1);
	assign q_prod    = 33'(b2_s3) * 33'(mr_s3);
	assign mg_prod   = 65'(y_s4) * 65'(Recip255);
	assign z_prod    = 48'(mr_s5) * 48'(mg_s5);
	assign mb_prod   = 65'(z_s6) * 65'(Recip255);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// twice the channels averaged with gray
			g2_s1 <= AvgW'(green) + AvgW'(gray);
			b2_s1 <= AvgW'(blue) + AvgW'(gray);
			p_s2  <= ProdW'(g2_s1) * ProdW'(b2_s1);
			b2_s2 <= b2_s1;
			mr_s3 <= mr_prod[50:27];
			b2_s3 <= b2_s2;
			// b2 * mr / 510 as (b2 * mr / 2) / 255
			y_s4  <= q_prod[32:1];
			mr_s4 <= mr_s3;
			mg_s5 <= mg_prod[63:40];
			mr_s5 <= mr_s4;
			z_s6  <= z_prod[47:16];
			mr_s6 <= mr_s5;
			mg_s6 <= mg_s5;
			mb_s7 <= mb_prod[63:40];
			mr_s7 <= mr_s6;
			mg_s7 <= mg_s6;
		end
	end

	assign mix_vld = v_s7;
	assign mix_r   = mr_s7;
	assign mix_g   = mg_s7;
	assign mix_b   = mb_s7;

endmodule
